// ===== sv/msrch_pkg.sv =====
// Types and constants shared by the medoid search block.
// No dependencies; compiled first.
`default_nettype none

package msrch_pkg;

    localparam int VIDX_W   = 10;
    localparam int CIDX_W   = 7;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 49;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VECTOR_COUNT    = 3'd0,
        CFG_COMPONENT_COUNT = 3'd1,
        CFG_FIRST_COMPONENT = 3'd2,
        CFG_RANGE_START     = 3'd3,
        CFG_RANGE_END       = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_RUN  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [10:0] vector_count;
        logic [7:0]  component_count;
        logic [6:0]  first_component;
        logic [9:0]  range_start;
        logic [10:0] range_end;
    } cfg_t;

    // One classified item as it travels through the queue.
    typedef struct packed {
        logic                is_run;
        logic [VIDX_W-1:0]   vector_index;
        logic [CIDX_W-1:0]   component_index;
        logic [SAMPLE_W-1:0] sample;
    } work_t;

endpackage

`default_nettype wire

// ===== sv/msrch_if.sv =====
// Handshake interfaces for the item and result channels.
// Depends on msrch_pkg.
`default_nettype none

interface msrch_item_if
    import msrch_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                command;
    logic [VIDX_W-1:0]   vector_index;
    logic [CIDX_W-1:0]   component_index;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, command, vector_index, component_index, sample,
                    input ready);
    modport sink   (input valid, command, vector_index, component_index, sample,
                    output ready);
endinterface

interface msrch_result_if
    import msrch_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [VIDX_W-1:0] medoid_index;
    logic [SUM_W-1:0]  medoid_sum;
    logic              found;

    modport source (output valid, medoid_index, medoid_sum, found, input ready);
    modport sink   (input valid, medoid_index, medoid_sum, found, output ready);
endinterface

`default_nettype wire

// ===== sv/msrch_front.sv =====
// Front stage: accepts items, drops loads outside the store, registers the rest.
// Depends on msrch_pkg and msrch_if.
`default_nettype none

module msrch_front
    import msrch_pkg::*;
#(
    parameter int MAX_VECTORS    = 1024,
    parameter int MAX_COMPONENTS = 128
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    msrch_item_if.sink  items,
    output work_t       work,
    output logic        work_valid,
    input  wire logic   work_ready
);

    logic  valid_reg, valid_next;
    work_t work_reg;
    logic  take, keep;

    assign items.ready = !valid_reg || work_ready;
    assign take        = items.valid && items.ready;
    // A load whose address lies outside the store is simply discarded here.
    assign keep = (items.command == CMD_RUN)
               || ((32'(items.vector_index) < MAX_VECTORS)
                   && (32'(items.component_index) < MAX_COMPONENTS));

    always_comb
    begin
        valid_next = valid_reg;
        if (work_ready)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next = keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            work_reg.is_run          <= items.command;
            work_reg.vector_index    <= items.vector_index;
            work_reg.component_index <= items.component_index;
            work_reg.sample          <= items.sample;
        end
    end

    assign work       = work_reg;
    assign work_valid = valid_reg;

endmodule

`default_nettype wire

// ===== sv/msrch_queue.sv =====
// Short queue between the front stage and the search engine.
// Depends on msrch_pkg.
`default_nettype none

module msrch_queue
    import msrch_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  work_t      push_data,
    input  wire logic  push_valid,
    output logic       push_ready,
    output work_t      pop_data,
    output logic       pop_valid,
    input  wire logic  pop_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    work_t            slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (32'(count_reg) < QUEUE_DEPTH);
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/msrch_engine.sv =====
// Back end: vector store, distance pipeline and running minimum search.
// Depends on msrch_pkg and msrch_if.
`default_nettype none

module msrch_engine
    import msrch_pkg::*;
#(
    parameter int MAX_VECTORS    = 1024,
    parameter int MAX_COMPONENTS = 128,
    parameter int SAMPLE_BITS    = 16
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  cfg_t          cfg,
    input  work_t         work,
    input  wire logic     work_valid,
    output logic          work_ready,
    msrch_result_if.source results
);

    localparam int VI_W  = $clog2(MAX_VECTORS);
    localparam int VC_W  = $clog2(MAX_VECTORS + 1);
    localparam int CI_W  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int CC_W  = $clog2(MAX_COMPONENTS + 1);
    localparam int DEPTH = MAX_VECTORS * MAX_COMPONENTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int D_W   = SAMPLE_BITS + 1;
    localparam int SQ_W  = 2 * SAMPLE_BITS + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic            kill;
        logic            last;
        logic            fin;
        logic [VI_W-1:0] j;
    } tag_t;

    state_t state_reg;

    // Store and its two registered read ports.
    logic [SAMPLE_BITS-1:0] store [DEPTH];
    logic [SAMPLE_BITS-1:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0]          addr_a, addr_b, addr_w;
    logic [SAMPLE_BITS+15:0] wide_sample;

    // Run settings captured when a run starts.
    logic [VC_W-1:0] nvec_reg, re_reg;
    logic [CC_W-1:0] ncomp_reg;
    logic [CI_W-1:0] c0_reg;
    logic            noterms_reg;
    logic [VI_W-1:0] j_reg, z_reg;
    logic [CI_W-1:0] c_reg;

    logic [VC_W-1:0] nvec_c, re_c;
    logic [CC_W-1:0] ncomp_c;
    logic            empty_c, noterms_c;

    // Pipeline: read, difference, square, accumulate.
    logic                 s1_v_reg, s2_v_reg, s3_v_reg;
    tag_t                 s1_tag_reg, s2_tag_reg, s3_tag_reg, issue_tag;
    logic signed [D_W-1:0] diff_reg;
    logic [SQ_W-1:0]      sq_reg;
    logic signed [2*D_W-1:0] prod;

    logic [SUM_W-1:0] acc_reg, best_sum_reg, total;
    logic [VI_W-1:0]  best_idx_reg;
    logic             found_reg, win;

    logic             out_valid_reg;
    logic [VIDX_W-1:0] out_idx_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic             out_found_reg;

    logic pop, pop_load, pop_run, last_c, last_z, last_j;

    assign nvec_c  = (32'(cfg.vector_count) > MAX_VECTORS) ? VC_W'(MAX_VECTORS)
                                                          : VC_W'(cfg.vector_count);
    assign ncomp_c = (32'(cfg.component_count) > MAX_COMPONENTS) ? CC_W'(MAX_COMPONENTS)
                                                               : CC_W'(cfg.component_count);
    assign re_c    = (32'(cfg.range_end) > MAX_VECTORS) ? VC_W'(MAX_VECTORS)
                                                       : VC_W'(cfg.range_end);
    assign empty_c   = (32'(cfg.range_start) >= 32'(re_c));
    assign noterms_c = (nvec_c == '0) || (32'(cfg.first_component) >= 32'(ncomp_c));

    assign work_ready = (state_reg == ST_IDLE) && (!work.is_run || !out_valid_reg);
    assign pop        = work_valid && work_ready;
    assign pop_load   = pop && !work.is_run;
    assign pop_run    = pop && work.is_run;

    assign last_c = (CC_W'(c_reg) == ncomp_reg - CC_W'(1));
    assign last_z = (VC_W'(z_reg) == nvec_reg - VC_W'(1));
    assign last_j = (VC_W'(j_reg) == re_reg - VC_W'(1));

    always_comb
    begin
        issue_tag.kill = noterms_reg || (z_reg == j_reg);
        issue_tag.last = noterms_reg || (last_z && last_c);
        issue_tag.fin  = issue_tag.last && last_j;
        issue_tag.j    = j_reg;
    end

    assign addr_a = AW'(j_reg) * AW'(MAX_COMPONENTS) + AW'(c_reg);
    assign addr_b = AW'(z_reg) * AW'(MAX_COMPONENTS) + AW'(c_reg);
    assign addr_w = AW'(work.vector_index) * AW'(MAX_COMPONENTS)
                  + AW'(work.component_index);
    // Samples above their native width read as unsigned, as the load field is 16 bits.
    assign wide_sample = {{SAMPLE_BITS{1'b0}}, work.sample};

    always_ff @(posedge clk)
    begin
        if (pop_load)
        begin
            store[addr_w] <= wide_sample[SAMPLE_BITS-1:0];
        end
        rd_a_reg <= store[addr_a];
        rd_b_reg <= store[addr_b];
    end

    assign prod  = diff_reg * diff_reg;
    assign total = acc_reg + (s3_tag_reg.kill ? SUM_W'(0) : SUM_W'(sq_reg));
    // Ties go to the later candidate.
    assign win   = !found_reg || (total <= best_sum_reg);

    always_ff @(posedge clk)
    begin
        diff_reg <= $signed({rd_a_reg[SAMPLE_BITS-1], rd_a_reg})
                  - $signed({rd_b_reg[SAMPLE_BITS-1], rd_b_reg});
        sq_reg   <= prod[SQ_W-1:0];
        s1_tag_reg <= issue_tag;
        s2_tag_reg <= s1_tag_reg;
        s3_tag_reg <= s2_tag_reg;
        if (pop_run)
        begin
            nvec_reg    <= nvec_c;
            ncomp_reg   <= ncomp_c;
            re_reg      <= re_c;
            c0_reg      <= CI_W'(cfg.first_component);
            noterms_reg <= noterms_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_sum_reg   <= '0;
            acc_reg       <= '0;
            best_sum_reg  <= '0;
            best_idx_reg  <= '0;
            j_reg         <= '0;
            z_reg         <= '0;
            c_reg         <= '0;
        end
        else
        begin
            s1_v_reg <= (state_reg == ST_ISSUE);
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            // A run only starts once the previous result has gone, so this never
            // meets a new result in the same cycle.
            if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop_run)
                    begin
                        if (empty_c)
                        begin
                            out_valid_reg <= 1'b1;
                            out_found_reg <= 1'b0;
                            out_idx_reg   <= '0;
                            out_sum_reg   <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_ISSUE;
                            j_reg     <= VI_W'(cfg.range_start);
                            z_reg     <= '0;
                            c_reg     <= CI_W'(cfg.first_component);
                            found_reg <= 1'b0;
                            acc_reg   <= '0;
                        end
                    end
                end
                ST_ISSUE:
                begin
                    if (issue_tag.last)
                    begin
                        if (issue_tag.fin)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        j_reg <= j_reg + 1'b1;
                        z_reg <= '0;
                        c_reg <= c0_reg;
                    end
                    else if (last_c)
                    begin
                        c_reg <= c0_reg;
                        z_reg <= z_reg + 1'b1;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                ST_DRAIN:
                begin
                    if (s3_v_reg && s3_tag_reg.fin)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b1;
                        out_found_reg <= 1'b1;
                        out_idx_reg   <= win ? VIDX_W'(s3_tag_reg.j) : VIDX_W'(best_idx_reg);
                        out_sum_reg   <= win ? total : best_sum_reg;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (s3_v_reg)
            begin
                if (s3_tag_reg.last)
                begin
                    acc_reg <= '0;
                    found_reg <= 1'b1;
                    if (win)
                    begin
                        best_sum_reg <= total;
                        best_idx_reg <= s3_tag_reg.j;
                    end
                end
                else
                begin
                    acc_reg <= total;
                end
            end
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.medoid_index = out_idx_reg;
    assign results.medoid_sum   = out_sum_reg;
    assign results.found        = out_found_reg;

endmodule

`default_nettype wire

// ===== sv/medoid_search.sv =====
// Top level of the medoid search block: configuration registers and the
// front stage, queue and search engine. Depends on msrch_pkg, msrch_if and submodules.
//
//  channel   direction  beat carries
//  items     in         command, vector_index, component_index, sample
//  results   out        medoid_index, medoid_sum, found
//  cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// A load beat is taken every cycle while the queue has room and is written to
// the store at the edge at which it leaves the queue.
// A run computes one squared difference per cycle, bounded by the two read ports
// of the vector store; an empty range answers as soon as the run leaves the queue.
// Reset clears control state only; the store holds nothing defined until loaded.
// A run whose result still waits to be taken holds back the next run.
`default_nettype none

module medoid_search
    import msrch_pkg::*;
#(
    parameter int MAX_VECTORS    = 1024,
    parameter int MAX_COMPONENTS = 128,
    parameter int SAMPLE_BITS    = 16
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    msrch_item_if.sink                 items,
    msrch_result_if.source             results,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    work_t front_work, queue_work;
    logic  front_valid, front_ready, queue_valid, queue_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vector_count    <= 11'd1;
            cfg_reg.component_count <= 8'd1;
            cfg_reg.first_component <= 7'd0;
            cfg_reg.range_start     <= 10'd0;
            cfg_reg.range_end       <= 11'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VECTOR_COUNT:    cfg_reg.vector_count    <= cfg_data[10:0];
                CFG_COMPONENT_COUNT: cfg_reg.component_count <= cfg_data[7:0];
                CFG_FIRST_COMPONENT: cfg_reg.first_component <= cfg_data[6:0];
                CFG_RANGE_START:     cfg_reg.range_start     <= cfg_data[9:0];
                CFG_RANGE_END:       cfg_reg.range_end       <= cfg_data[10:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    msrch_front #(
        .MAX_VECTORS    (MAX_VECTORS),
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .work       (front_work),
        .work_valid (front_valid),
        .work_ready (front_ready)
    );

    msrch_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_work),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (queue_work),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    msrch_engine #(
        .MAX_VECTORS    (MAX_VECTORS),
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .work       (queue_work),
        .work_valid (queue_valid),
        .work_ready (queue_ready),
        .results    (results)
    );

endmodule

`default_nettype wire

// ===== sv/msrch_checker.sv =====
// Port-level checks on the medoid search block, bound to its top level.
// Depends on msrch_pkg.
`default_nettype none

module msrch_checker
    import msrch_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [VIDX_W-1:0] res_index,
    input wire logic [SUM_W-1:0]  res_sum,
    input wire logic              res_found
);

    // A waiting result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before it was taken");

    // An empty range reports zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> (res_index == '0) && (res_sum == '0))
        else $error("empty range with non-zero fields");

    // Nothing is offered straight out of reset.
    assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result offered after reset");

    // A result taken is not offered again in the next cycle without a new run,
    // which the engine does not accept while a result still waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> !res_valid)
        else $error("result repeated");

endmodule

bind medoid_search msrch_checker u_msrch_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_index (results.medoid_index),
    .res_sum   (results.medoid_sum),
    .res_found (results.found)
);

`default_nettype wire
